// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int LEN_W               = 24;
  localparam int HEADER_BYTES        = 16;
  localparam int ALIGN_MASK          = 'hF;
  localparam int MAX_BLOCKS_DEF      = 64;
  localparam int HEAP_ADDR_BITS_DEF  = 23;
  localparam logic [LEN_W-1:0] HEAP_RESET = 24'd8388608;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  // Control from the sequencer to the row of table cells.
  typedef struct packed {
    logic shift;
  } chain_ctl_t;

endpackage

// ===== hw/rtl/ffha_cell.sv =====
// One entry of the block table: payload offset and length.
// Depends on ffha_pkg for the length width and the chain control struct.
`timescale 1ns / 1ps

module ffha_cell #(
  parameter int HEAP_ADDR_BITS = ffha_pkg::HEAP_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  ffha_pkg::chain_ctl_t       ctl,
  input  logic [HEAP_ADDR_BITS-1:0]  start_in,
  input  logic [ffha_pkg::LEN_W-1:0] len_in,
  output logic [HEAP_ADDR_BITS-1:0]  start_r,
  output logic [ffha_pkg::LEN_W-1:0] len_r
);
  import ffha_pkg::*;

  // Take the neighbor's entry on every shift, hold otherwise.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      start_r <= start_in;
      len_r   <= len_in;
    end
  end

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Sequencer: handshakes, statistics and the first-fit walk over the cell row.
// Depends on ffha_pkg; drives the tail of the chain built in the top level.
`timescale 1ns / 1ps

module ffha_ctrl #(
  parameter int MAX_BLOCKS     = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_ADDR_BITS = ffha_pkg::HEAP_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [ffha_pkg::LEN_W-1:0] in_request_bytes,
  input  logic [HEAP_ADDR_BITS-1:0]  in_block_address,
  input  logic                       cfg_we,
  input  logic [ffha_pkg::LEN_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [HEAP_ADDR_BITS-1:0]  out_payload_offset,
  output logic [ffha_pkg::LEN_W-1:0] out_bytes_used,
  output logic [ffha_pkg::LEN_W-1:0] out_heap_size_out,
  output logic [ffha_pkg::LEN_W-1:0] out_peak_used,
  output ffha_pkg::chain_ctl_t       ctl,
  input  logic [HEAP_ADDR_BITS-1:0]  head_start,
  input  logic [ffha_pkg::LEN_W-1:0] head_len,
  input  logic [HEAP_ADDR_BITS-1:0]  next_start,
  input  logic [ffha_pkg::LEN_W-1:0] next_len,
  output logic [HEAP_ADDR_BITS-1:0]  push_start,
  output logic [ffha_pkg::LEN_W-1:0] push_len
);
  import ffha_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = ((HEAP_ADDR_BITS > LEN_W) ? HEAP_ADDR_BITS : LEN_W) + 3;
  localparam logic [SW-1:0] ADDR_SPAN = SW'(64'd1 << HEAP_ADDR_BITS);
  localparam logic [SW-1:0] ADDR_MAX  = SW'((64'd1 << HEAP_ADDR_BITS) - 64'd1);
  localparam logic [SW-1:0] HDR       = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] AMASK     = SW'(ALIGN_MASK);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;
  typedef enum logic [1:0] {M_PASS, M_INS, M_DEL} mode_t;

  state_t                  state_r;
  mode_t                   mode_r;
  logic                    kind_r;
  logic [LEN_W-1:0]        req_r;
  logic [HEAP_ADDR_BITS-1:0] addr_r;
  logic [CW-1:0]           idx_r;
  logic [CW-1:0]           live_r;
  logic [SW-1:0]           np_r;
  logic [HEAP_ADDR_BITS-1:0] hold_start_r;
  logic [LEN_W-1:0]        hold_len_r;
  logic                    decided_r;
  status_t                 status_r;
  logic [HEAP_ADDR_BITS-1:0] pay_r;
  logic [LEN_W-1:0]        used_r;
  logic [LEN_W-1:0]        peak_r;
  logic [LEN_W-1:0]        heap_r;
  logic [LEN_W-1:0]        peak_nxt;

  logic          valid_e, last, fit_mid, fit_end, pay_ok, match, ins_now, del_now;
  logic [SW-1:0] size_w, hs_w, hl_w, end_w, pay_w, np_step;

  assign in_ready  = (state_r == S_IDLE);
  assign ctl.shift = (state_r == S_WALK);

  always_comb begin
    valid_e = idx_r < live_r;
    last    = idx_r == CW'(MAX_BLOCKS - 1);
    size_w  = SW'(req_r);
    hs_w    = SW'(head_start);
    hl_w    = SW'(head_len);
    end_w   = (SW'(heap_r) > ADDR_SPAN) ? ADDR_SPAN : SW'(heap_r);
    pay_w   = np_r + HDR;
    np_step = (hs_w + hl_w + AMASK) & ~AMASK;
    fit_mid = valid_e && (hs_w >= HDR) && (hs_w >= np_r + HDR + HDR + size_w);
    fit_end = !valid_e && (np_r + HDR + size_w <= end_w);
    pay_ok  = pay_w <= ADDR_MAX;
    match   = valid_e && (head_start == addr_r);
    ins_now = !decided_r && (kind_r == KIND_ALLOC) && (fit_mid || fit_end) && pay_ok;
    del_now = !decided_r && (kind_r == KIND_FREE) && match;
    peak_nxt = (used_r > peak_r) ? used_r : peak_r;

    // Tail feed: the head itself when passing, a new entry, the delayed stream after
    // an insert, or the stream advanced by one after a delete (empty entry closes the ring).
    if (ins_now) begin
      push_start = pay_w[HEAP_ADDR_BITS-1:0];
      push_len   = req_r;
    end else if (del_now || mode_r == M_DEL) begin
      push_start = last ? '0 : next_start;
      push_len   = last ? '0 : next_len;
    end else if (mode_r == M_INS) begin
      push_start = hold_start_r;
      push_len   = hold_len_r;
    end else begin
      push_start = head_start;
      push_len   = head_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      used_r    <= LEN_W'(HEADER_BYTES);
      peak_r    <= LEN_W'(HEADER_BYTES);
      heap_r    <= HEAP_RESET;
      out_valid <= 1'b0;
      decided_r <= 1'b0;
      mode_r    <= M_PASS;
    end else begin
      if (cfg_we) begin
        heap_r <= cfg_wdata;
      end
      // Drop valid after a transfer unless a new result replaces it.
      if (out_valid && out_ready && state_r != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_kind;
            req_r     <= in_request_bytes;
            addr_r    <= in_block_address;
            idx_r     <= '0;
            np_r      <= HDR;
            decided_r <= 1'b0;
            mode_r    <= M_PASS;
            pay_r     <= '0;
            if (in_kind == KIND_ALLOC && live_r == CW'(MAX_BLOCKS)) begin
              status_r <= ST_TABLE_FULL;
              state_r  <= S_FIN;
            end else if (in_kind == KIND_FREE && in_block_address == '0) begin
              status_r <= ST_OK;
              state_r  <= S_FIN;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_WALK;
            end
          end
        end
        S_WALK: begin
          hold_start_r <= head_start;
          hold_len_r   <= head_len;
          idx_r        <= idx_r + CW'(1);
          if (!decided_r) begin
            if (kind_r == KIND_ALLOC) begin
              if (fit_mid || fit_end) begin
                decided_r <= 1'b1;
                if (pay_ok) begin
                  mode_r <= M_INS;
                  live_r <= live_r + CW'(1);
                  used_r <= used_r + req_r + LEN_W'(HEADER_BYTES);
                  pay_r  <= pay_w[HEAP_ADDR_BITS-1:0];
                end else begin
                  status_r <= ST_NO_SPACE;
                end
              end else if (!valid_e) begin
                decided_r <= 1'b1;
                status_r  <= ST_NO_SPACE;
              end else begin
                np_r <= np_step;
              end
            end else if (match) begin
              decided_r <= 1'b1;
              mode_r    <= M_DEL;
              live_r    <= live_r - CW'(1);
              used_r    <= used_r - (head_len + LEN_W'(HEADER_BYTES));
            end
          end
          if (last) begin
            state_r <= S_FIN;
            if (kind_r == KIND_FREE && !decided_r && !match) begin
              status_r <= ST_NOT_FOUND;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_status         <= status_r;
            out_payload_offset <= pay_r;
            out_bytes_used     <= used_r;
            out_heap_size_out  <= heap_r;
            out_peak_used      <= peak_nxt;
            peak_r             <= peak_nxt;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator: a row of table cells rotating past a sequencer.
// Pass through every entry of the address-sorted table, one entry per clock.
// An allocate or free that needs the table is accepted, walks the whole table
// and then posts its result. The walk length is set by the cell ring, which
// makes one full revolution per item so that an insert or delete reshapes
// it in the same pass. A refused allocate on a full table and a free of
// offset zero skip the walk and go from acceptance straight to the result.
// One item is in the block at a time; a finished result waits in the output
// register, and the next transfer is accepted while it waits. The heap size
// register takes writes at any edge with cfg_we high and is echoed in every
// result. Table entries are not cleared at reset; the live count and statistics are.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS     = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_ADDR_BITS = ffha_pkg::HEAP_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [ffha_pkg::LEN_W-1:0] in_request_bytes,
  input  logic [HEAP_ADDR_BITS-1:0]  in_block_address,
  input  logic                       cfg_we,
  input  logic [ffha_pkg::LEN_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [HEAP_ADDR_BITS-1:0]  out_payload_offset,
  output logic [ffha_pkg::LEN_W-1:0] out_bytes_used,
  output logic [ffha_pkg::LEN_W-1:0] out_heap_size_out,
  output logic [ffha_pkg::LEN_W-1:0] out_peak_used
);
  import ffha_pkg::*;

  // Second cell feeds the tail during a delete; a one-entry table has none.
  localparam int NEXT_IDX = (MAX_BLOCKS > 1) ? 1 : 0;

  chain_ctl_t              ctl;
  logic [HEAP_ADDR_BITS-1:0] cell_start [MAX_BLOCKS];
  logic [LEN_W-1:0]        cell_len   [MAX_BLOCKS];
  logic [HEAP_ADDR_BITS-1:0] push_start;
  logic [LEN_W-1:0]        push_len;

  ffha_ctrl #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_request_bytes   (in_request_bytes),
    .in_block_address   (in_block_address),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_bytes_used     (out_bytes_used),
    .out_heap_size_out  (out_heap_size_out),
    .out_peak_used      (out_peak_used),
    .ctl                (ctl),
    .head_start         (cell_start[0]),
    .head_len           (cell_len[0]),
    .next_start         (cell_start[NEXT_IDX]),
    .next_len           (cell_len[NEXT_IDX]),
    .push_start         (push_start),
    .push_len           (push_len)
  );

  // Cell 0 is the head the sequencer inspects; the tail takes its feed.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    if (i == MAX_BLOCKS - 1) begin : g_tail
      ffha_cell #(.HEAP_ADDR_BITS(HEAP_ADDR_BITS)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .start_in (push_start),
        .len_in   (push_len),
        .start_r  (cell_start[i]),
        .len_r    (cell_len[i])
      );
    end else begin : g_mid
      ffha_cell #(.HEAP_ADDR_BITS(HEAP_ADDR_BITS)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .start_in (cell_start[i+1]),
        .len_in   (cell_len[i+1]),
        .start_r  (cell_start[i]),
        .len_r    (cell_len[i])
      );
    end
  end

endmodule

// ===== hw/rtl/ffha_checker.sv =====
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg for status codes and field widths.
`timescale 1ns / 1ps

module ffha_checker #(
  parameter int MAX_BLOCKS     = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_ADDR_BITS = ffha_pkg::HEAP_ADDR_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       cfg_we,
  input logic [ffha_pkg::LEN_W-1:0] cfg_wdata,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [HEAP_ADDR_BITS-1:0]  out_payload_offset,
  input logic [ffha_pkg::LEN_W-1:0] out_bytes_used,
  input logic [ffha_pkg::LEN_W-1:0] out_heap_size_out,
  input logic [ffha_pkg::LEN_W-1:0] out_peak_used
);
  import ffha_pkg::*;

  localparam int CHK_BLOCKS = MAX_BLOCKS;

  logic [LEN_W-1:0] heap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= HEAP_RESET;
    end else if (cfg_we) begin
      heap_r <= cfg_wdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped before transfer");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n || CHK_BLOCKS == 0)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during a walk");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_used >= out_bytes_used)
    else $error("peak below bytes used");

  a_heap_echo: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !$past(cfg_we) |-> out_heap_size_out == heap_r)
    else $error("heap size echo mismatch");

  a_pay_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_offset != '0 |-> out_status == ST_OK)
    else $error("payload offset on a failed step");

endmodule

bind first_fit_heap_allocator_core ffha_checker #(
  .MAX_BLOCKS     (MAX_BLOCKS),
  .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
) u_ffha_checker (.*);
